// ===== hdl/csm_pkg.sv =====
package csm_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ENTRY = 2'd1,
    OP_EMPTY = 2'd2
  } op_e;

  localparam int unsigned IDX_W   = 12;  // load index, column and row index width
  localparam int unsigned DATA_W  = 32;  // Q16.16 operand and result width
  localparam int unsigned ACC_W   = 64;  // row accumulator width
  localparam int unsigned FRACTION_BITS = 16;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] SUM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SUM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ===== hdl/csm_ram.sv =====
module csm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/csr_sparse_matvec_top.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | input     | in_valid_i / in_ready_o | operation, load_index, vector_value,
//          |           |                        | column, matrix_value, last_in_row, last_row
// out      | output    | out_valid_o / out_ready_i | row_index, row_sum, saturated, matrix_done
//
// One item is accepted per cycle while in_ready_o is high. A row result passes the vector
// store read at the accepting edge, the 32x32 multiply into the product register, then
// accumulate and clip into the output register.
// Input stalls only while a finished result waits in the output register and the
// next closing item reaches the accumulate stage. Reset clears the accumulator, row
// counter and all valid flags; the vector store is not cleared and needs no pass.
module csr_sparse_matvec_top #(
  parameter int unsigned VECTOR_DEPTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [csm_pkg::IDX_W-1:0]   load_index_i,
  input  logic signed [csm_pkg::DATA_W-1:0] vector_value_i,
  input  logic [csm_pkg::IDX_W-1:0]   column_i,
  input  logic signed [csm_pkg::DATA_W-1:0] matrix_value_i,
  input  logic                        last_in_row_i,
  input  logic                        last_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [csm_pkg::IDX_W-1:0]   row_index_o,
  output logic signed [csm_pkg::DATA_W-1:0] row_sum_o,
  output logic                        saturated_o,
  output logic                        matrix_done_o
);

  import csm_pkg::*;

  localparam int unsigned AW = $clog2(VECTOR_DEPTH);

  // Stage 1: item after vector store read
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_entry_q;
  logic                     s1_close_q;
  logic                     s1_last_q;
  logic                     s1_in_range_q;
  logic signed [DATA_W-1:0] s1_a_q;

  // Stage 2: product register
  logic                     s2_valid_q;
  logic                     s2_entry_q;
  logic                     s2_close_q;
  logic                     s2_last_q;
  logic signed [ACC_W-1:0]  s2_prod_q, s2_prod_d;

  // Accumulator, row counter and output register
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [IDX_W-1:0]         row_q, row_d;
  logic                     out_valid_q, out_valid_d;
  logic [IDX_W-1:0]         out_row_q;
  logic signed [DATA_W-1:0] out_sum_q, out_sum_d;
  logic                     out_sat_q, out_sat_d;
  logic                     out_done_q;

  logic                     adv;
  logic                     in_accept;
  logic                     is_load, is_entry, is_empty;
  logic                     load_in_range, col_in_range;
  logic [AW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] rdata, x_sel;
  logic signed [ACC_W-1:0]  shifted, acc_new;
  logic signed [ACC_W:0]    sum_wide;
  logic                     s2_fire;

  // Stall only when a closing item meets a full, unread output register
  assign adv        = !(s2_valid_q && s2_close_q && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // Decode the operation
  always_comb begin
    is_load  = 1'b0;
    is_entry = 1'b0;
    is_empty = 1'b0;
    case (operation_i)
      OP_LOAD:  is_load  = 1'b1;
      OP_ENTRY: is_entry = 1'b1;
      OP_EMPTY: is_empty = 1'b1;
      default:  ;
    endcase
  end

  assign load_in_range = 32'(load_index_i) < VECTOR_DEPTH;
  assign col_in_range  = 32'(column_i) < VECTOR_DEPTH;
  assign waddr         = AW'(load_index_i);
  assign raddr         = AW'(column_i);

  csm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && is_load && load_in_range),
    .waddr_i (waddr),
    .wdata_i (vector_value_i),
    .re_i    (in_accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Stage 1 control
  assign s1_valid_d = in_accept && (is_entry || is_empty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 1 payload, captured with the read
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_entry_q    <= is_entry;
      s1_close_q    <= is_empty || last_in_row_i;
      s1_last_q     <= last_row_i;
      s1_in_range_q <= col_in_range;
      s1_a_q        <= matrix_value_i;
    end
  end

  // Multiply the entry by its vector element; out-of-range columns read zero
  assign x_sel     = s1_in_range_q ? rdata : '0;
  assign s2_prod_d = ACC_W'(s1_a_q) * ACC_W'(x_sel);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_entry_q <= s1_entry_q;
      s2_close_q <= s1_close_q;
      s2_last_q  <= s1_last_q;
      s2_prod_q  <= s2_prod_d;
    end
  end

  // Scale the product down (floor) and add with 64-bit saturation
  assign shifted  = s2_prod_q >>> FRACTION_BITS;
  assign sum_wide = (ACC_W+1)'(shifted) + (ACC_W+1)'(acc_q);

  always_comb begin
    if (!s2_entry_q) begin
      acc_new = acc_q;
    end else begin
      case (sum_wide[ACC_W:ACC_W-1])
        2'b01:   acc_new = ACC_MAX;
        2'b10:   acc_new = ACC_MIN;
        default: acc_new = sum_wide[ACC_W-1:0];
      endcase
    end
  end

  // Clip the row sum to 32 bits
  always_comb begin
    if (&acc_new[ACC_W-1:DATA_W-1] || ~|acc_new[ACC_W-1:DATA_W-1]) begin
      out_sum_d = acc_new[DATA_W-1:0];
      out_sat_d = 1'b0;
    end else begin
      out_sum_d = acc_new[ACC_W-1] ? SUM_MIN : SUM_MAX;
      out_sat_d = 1'b1;
    end
  end

  assign s2_fire = s2_valid_q && adv;

  // Advance accumulator and row counter; on row close clear the accumulator and step the row (zero after last row)
  always_comb begin
    acc_d = acc_q;
    row_d = row_q;
    if (s2_fire) begin
      if (s2_close_q) begin
        acc_d = '0;
        row_d = s2_last_q ? '0 : row_q + 1'b1;
      end else begin
        acc_d = acc_new;
      end
    end
  end

  // Output register valid: load on close, drop when taken
  always_comb begin
    if (s2_fire && s2_close_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_close_q) begin
      out_row_q  <= row_q;
      out_sum_q  <= out_sum_d;
      out_sat_q  <= out_sat_d;
      out_done_q <= s2_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_index_o   = out_row_q;
  assign row_sum_o     = out_sum_q;
  assign saturated_o   = out_sat_q;
  assign matrix_done_o = out_done_q;

endmodule

// ===== hdl/csm_checker.sv =====
module csm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [csm_pkg::IDX_W-1:0]   row_index_o,
  input logic signed [csm_pkg::DATA_W-1:0] row_sum_o,
  input logic                        saturated_o,
  input logic                        matrix_done_o
);

  import csm_pkg::*;

  // Hold a pending result until the transaction completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before acceptance");

  // Keep the result payload stable while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(row_index_o) && $stable(row_sum_o) &&
      $stable(saturated_o) && $stable(matrix_done_o))
    else $error("result payload changed while stalled");

  // Input backpressure only comes from a full, unread output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A clipped sum sits at one of the 32-bit limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> row_sum_o == SUM_MAX || row_sum_o == SUM_MIN)
    else $error("saturated row sum is not at a limit");

endmodule

bind csr_sparse_matvec_top csm_checker u_csm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .row_index_o   (row_index_o),
  .row_sum_o     (row_sum_o),
  .saturated_o   (saturated_o),
  .matrix_done_o (matrix_done_o)
);
